### rtl/gtg_pkg.sv
// Shared types and constants for the go-to-goal pursuit controller.
// Used by gtg_ctrl, gtg_datapath and the top level.
package gtg_pkg;

  localparam int unsigned PiQ16     = 205887;
  localparam int unsigned TwoPiQ16  = 411775;
  localparam int unsigned HalfPiQ16 = 102944;
  localparam int unsigned SpeedMax  = 131071;
  localparam int unsigned RateMax   = 25736;
  localparam int unsigned SqrtSteps = 18;

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_POSE     = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  localparam logic [1:0] CfgLinGain  = 2'd0;
  localparam logic [1:0] CfgAngGain  = 2'd1;
  localparam logic [1:0] CfgThresh   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch operands and start root and CORDIC setup
    logic step;     // one root step and one CORDIC step
    logic finish;   // form distance, error and caught flag
    logic scale;    // scale distance and error by the gains
    logic emit;     // drive the result strobe
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
  } dp_sts_t;

  // Arctangent table in 1/65536 radian.
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] r;
    begin
      case (idx)
        5'd0:  r = 17'd51472;
        5'd1:  r = 17'd30386;
        5'd2:  r = 17'd16055;
        5'd3:  r = 17'd8150;
        5'd4:  r = 17'd4091;
        5'd5:  r = 17'd2047;
        5'd6:  r = 17'd1024;
        5'd7:  r = 17'd512;
        5'd8:  r = 17'd256;
        5'd9:  r = 17'd128;
        5'd10: r = 17'd64;
        5'd11: r = 17'd32;
        5'd12: r = 17'd16;
        5'd13: r = 17'd8;
        5'd14: r = 17'd4;
        5'd15: r = 17'd2;
        5'd16: r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/gtg_ctrl.sv
// Sequencer for the go-to-goal controller: steps the datapath through one tick.
// Depends on gtg_pkg.
module gtg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  output logic             busy_o,
  output gtg_pkg::dp_cmd_t cmd_o,
  input  gtg_pkg::dp_sts_t sts_i
);
  import gtg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_ITER   = 6'b000100,
    ST_FINISH = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   if (tick_i) state_d = ST_LOAD;
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        if (sts_i.sqrt_done && sts_i.cordic_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_emit_after_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> $past(cmd_o.scale))
    else $error("emit without scale");
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && tick_i) |=> cmd_o.load)
    else $error("tick did not load");

endmodule

### rtl/gtg_datapath.sv
// Datapath: slot table, pose, bit-serial square root, iterative CORDIC and scaling.
// Depends on gtg_pkg; sequenced by gtg_ctrl.
module gtg_datapath #(
  parameter int unsigned TargetSlots = 8,
  parameter int unsigned CordicSteps = 16,
  localparam int unsigned IdW = (TargetSlots > 1) ? $clog2(TargetSlots) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       mode_i,
  input  logic [2:0]       target_id_i,
  input  logic [15:0]      pos_x_i,
  input  logic [15:0]      pos_y_i,
  input  logic signed [14:0] heading_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  gtg_pkg::dp_cmd_t cmd_i,
  output gtg_pkg::dp_sts_t sts_o,
  output logic             found_o,
  output logic             done_o,
  output logic [16:0]      linear_speed_o,
  output logic signed [15:0] angular_rate_o,
  output logic             caught_o,
  output logic [2:0]       chased_id_o
);
  import gtg_pkg::*;

  localparam int unsigned CW = 38;  // CORDIC x/y width: 17-bit delta * 2^14 plus growth

  logic [11:0] lin_gain_q, ang_gain_q;
  logic [15:0] thresh_q;
  logic [TargetSlots-1:0] valid_q;
  logic [15:0] slot_x_q [TargetSlots];
  logic [15:0] slot_y_q [TargetSlots];
  logic [15:0] pur_x_q, pur_y_q;
  logic signed [14:0] pur_hd_q;

  // Priority pick of the lowest valid slot.
  logic [IdW-1:0] pick;
  always_comb begin
    pick = '0;
    found_o = 1'b0;
    for (int k = TargetSlots - 1; k >= 0; k--) begin
      if (valid_q[k]) begin
        pick = IdW'(k);
        found_o = 1'b1;
      end
    end
  end

  logic [IdW-1:0] id_q;
  logic [34:0] rem_q, res_q, bit_q;
  logic [4:0] sq_cnt_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [19:0] cz_q;
  logic [4:0] co_cnt_q;
  logic [16:0] dist_q;
  logic signed [16:0] dx_w, dy_w;
  logic [16:0] speed_q;
  logic signed [19:0] err_q;
  logic signed [15:0] rate_q;
  logic caught_q;

  assign dx_w = $signed({1'b0, slot_x_q[pick]}) - $signed({1'b0, pur_x_q});
  assign dy_w = $signed({1'b0, slot_y_q[pick]}) - $signed({1'b0, pur_y_q});

  logic [33:0] sum_sq;
  logic [16:0] adx, ady;
  always_comb begin
    adx = dx_w[16] ? 17'(-dx_w) : 17'(dx_w);
    ady = dy_w[16] ? 17'(-dy_w) : 17'(dy_w);
    sum_sq = 34'(adx * adx) + 34'(ady * ady);
  end

  logic [34:0] trial;
  assign trial = res_q + bit_q;

  logic signed [CW-1:0] sx, sy;
  assign sx = cx_q >>> co_cnt_q;
  assign sy = cy_q >>> co_cnt_q;

  logic signed [CW-1:0] x0, y0;
  logic signed [19:0] z0;
  always_comb begin
    x0 = CW'(dx_w) <<< 14;
    y0 = CW'(dy_w) <<< 14;
    z0 = '0;
    if (dx_w < 0) begin
      if (dy_w >= 0) begin
        x0 = CW'(dy_w) <<< 14;
        y0 = -(CW'(dx_w) <<< 14);
        z0 = 20'(HalfPiQ16);
      end else begin
        x0 = -(CW'(dy_w) <<< 14);
        y0 = CW'(dx_w) <<< 14;
        z0 = -20'(HalfPiQ16);
      end
    end
  end

  logic [28:0] lin_prod;
  logic [17:0] lin_rnd;
  logic signed [19:0] e1, e2;
  logic signed [32:0] ang_prod;
  logic signed [20:0] ang_sh;
  assign lin_prod = 29'(dist_q * lin_gain_q) + 29'd128;
  assign lin_rnd = lin_prod[28:8] > 21'(SpeedMax) ? 18'(SpeedMax) : 18'(lin_prod[28:8]);
  always_comb begin
    e1 = cz_q - 20'(pur_hd_q * 16);
    e2 = e1;
    if (e1 > 20'sd205887) e2 = e1 - 20'sd411775;
    if (e2 < -20'sd205887) e2 = e2 + 20'sd411775;
  end
  assign ang_prod = err_q * $signed({1'b0, ang_gain_q}) + 33'sd2048;
  assign ang_sh = 21'(ang_prod >>> 12);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= 12'd384;
      ang_gain_q <= 12'd512;
      thresh_q <= 16'd410;
      valid_q <= '0;
      pur_x_q <= '0;
      pur_y_q <= '0;
      pur_hd_q <= '0;
      sq_cnt_q <= '0;
      co_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLinGain: lin_gain_q <= cfg_data_i[11:0];
          CfgAngGain: ang_gain_q <= cfg_data_i[11:0];
          CfgThresh:  thresh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i && mode_i == MODE_REGISTER && 32'(target_id_i) < TargetSlots)
        valid_q[IdW'(target_id_i)] <= 1'b1;
      if (accept_i && mode_i == MODE_POSE) begin
        pur_x_q <= pos_x_i;
        pur_y_q <= pos_y_i;
        pur_hd_q <= heading_i;
      end
      if (cmd_i.load) begin
        sq_cnt_q <= '0;
        co_cnt_q <= '0;
      end
      if (cmd_i.step) begin
        if (sq_cnt_q != 5'(SqrtSteps)) sq_cnt_q <= sq_cnt_q + 5'd1;
        if (co_cnt_q != 5'(CordicSteps)) co_cnt_q <= co_cnt_q + 5'd1;
      end
      if (cmd_i.scale && caught_q) valid_q[id_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && mode_i == MODE_REGISTER && 32'(target_id_i) < TargetSlots) begin
      slot_x_q[IdW'(target_id_i)] <= pos_x_i;
      slot_y_q[IdW'(target_id_i)] <= pos_y_i;
    end
    if (cmd_i.load) begin
      id_q <= pick;
      rem_q <= 35'(sum_sq);
      res_q <= '0;
      bit_q <= 35'd1 << 34;
      cx_q <= x0;
      cy_q <= y0;
      cz_q <= z0;
    end
    if (cmd_i.step) begin
      if (sq_cnt_q != 5'(SqrtSteps)) begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      if (co_cnt_q != 5'(CordicSteps)) begin
        if (cy_q > 0) begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + 20'(atan_q16(co_cnt_q));
        end else begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - 20'(atan_q16(co_cnt_q));
        end
      end
    end
    if (cmd_i.finish) begin
      dist_q <= res_q[16:0];
      err_q <= e2;
      caught_q <= (res_q[16:0] <= 17'(thresh_q));
    end
    if (cmd_i.scale) begin
      speed_q <= lin_rnd[16:0];
      if (ang_sh > 21'sd25736) rate_q <= 16'sd25736;
      else if (ang_sh < -21'sd25736) rate_q <= -16'sd25736;
      else rate_q <= 16'(ang_sh);
    end
  end

  assign sts_o.sqrt_done = (sq_cnt_q == 5'(SqrtSteps));
  assign sts_o.cordic_done = (co_cnt_q == 5'(CordicSteps));
  assign done_o = cmd_i.emit;
  assign linear_speed_o = caught_q ? 17'd0 : speed_q;
  assign angular_rate_o = caught_q ? 16'sd0 : rate_q;
  assign caught_o = caught_q;
  assign chased_id_o = 3'(id_q);

  a_sqrt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_cnt_q <= 5'(SqrtSteps)) else $error("root counter overran");
  a_cordic_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    co_cnt_q <= 5'(CordicSteps)) else $error("CORDIC counter overran");
  a_clear_caught: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scale && caught_q) |=> !valid_q[id_q]) else $error("caught slot not cleared");

endmodule

### rtl/go_to_goal_pursuit_controller.sv
// Go-to-goal pursuit controller. Register and pose items are stored on their
// accepting edge. A control tick with a valid target steps through load,
// iteration (root steps with CORDIC steps alongside, until both report done),
// finish and scale, and raises done_o in emit. busy is high from load through
// emit and no item is accepted meanwhile; the bit-serial root sets its length.
// Ticks with no valid target give no result. done_o pulses once per result;
// the result outputs hold until a later tick. Reset (rst_ni low, asynchronous)
// clears all slots and the pose and returns the gains and threshold to defaults.
module go_to_goal_pursuit_controller #(
  parameter int unsigned TARGET_SLOTS = 8,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         target_id_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic signed [14:0] heading_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output logic               done_o,
  output logic [16:0]        linear_speed_o,
  output logic signed [15:0] angular_rate_o,
  output logic               caught_o,
  output logic [2:0]         chased_id_o
);
  import gtg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic accept, found;

  assign accept = start && !busy;

  gtg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (accept && mode_i == MODE_TICK && found),
    .busy_o (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  gtg_datapath #(
    .TargetSlots (TARGET_SLOTS),
    .CordicSteps (CORDIC_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .mode_i         (mode_i),
    .target_id_i    (target_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .heading_i      (heading_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .found_o        (found),
    .done_o         (done_o),
    .linear_speed_o (linear_speed_o),
    .angular_rate_o (angular_rate_o),
    .caught_o       (caught_o),
    .chased_id_o    (chased_id_o)
  );

endmodule
